FILE: rtl/core/pcmrs_pkg.sv
// pcmrs_pkg: shared types, codes and helpers of the pcm playback ramp sequencer
// depends on nothing; used by the top level, its checker and the testbench
package pcmrs_pkg;

  typedef enum logic [2:0] {
    MODE_STOPPED   = 3'd0,
    MODE_STARTING  = 3'd1,
    MODE_PLAYING   = 3'd2,
    MODE_FINISHING = 3'd3,
    MODE_FINISHED  = 3'd4,
    MODE_STOPPING  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [7:0] STOP_LEVEL   = 8'd0;
  localparam logic [7:0] REST_DEFAULT = 8'd127;

  // output tdata layout
  localparam int OUT_BUSY_BIT = 24;
  localparam int OUT_DONE_BIT = 25;
  localparam int OUT_TICK_BIT = 26;
  localparam int OUT_MODE_LSB = 27;
  localparam int OUT_MODE_MSB = 29;

  function automatic logic [7:0] step_toward(input logic [7:0] level, input logic [7:0] goal);
    logic [7:0] res;
    res = level;
    if (level > goal) begin
      res = level - 8'd1;
    end else if (level < goal) begin
      res = level + 8'd1;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/pcm_playback_ramp_sequencer.sv
// pcm_playback_ramp_sequencer: click-free clip playback sequencer, top level
// depends on pcmrs_pkg
//
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | tuser req_type, tdata sample/length
// out_    | out | out_tvalid/out_tready | tdata level/index/flags/mode
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_data rest_level
//
// one result per request; an accepted request passes the input register, then the result register, to out_tvalid
// a new request is taken every cycle while the output side keeps up
// the sequencer state updates as a request leaves the input register
// a stalled result holds the input register; one more request waits there
// rst_n clears state to stopped, level zero, rest level 127
module pcm_playback_ramp_sequencer #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample_value[7:0], clip_length[23:8]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pwm_level[7:0], read_index[23:8], busy_res[24],
                                  // done_res[25], tick_enable[26], mode[29:27], zero[31:30]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CMP_W = (INDEX_BITS > 16) ? INDEX_BITS : 16;

  logic                  s1_valid_r;
  pcmrs_pkg::req_t       s1_req_r;
  logic [7:0]            s1_sample_r;
  logic [15:0]           s1_len_r;
  logic                  s1_adv;

  pcmrs_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]            level_r, level_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [15:0]           len_r, len_nxt;
  logic                  loaded_r, loaded_nxt;
  logic                  tick_r, tick_nxt;
  logic                  done_nxt;
  logic [7:0]            rest_r;
  logic [CMP_W-1:0]      idx_ext;

  logic                  out_valid_r;
  logic [31:0]           out_data_r;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    mode_nxt   = mode_r;
    level_nxt  = level_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    len_nxt    = len_r;
    loaded_nxt = loaded_r;
    tick_nxt   = tick_r;
    done_nxt   = 1'b0;
    if (s1_req_r == pcmrs_pkg::REQ_START) begin
      idx_nxt    = '0;
      first_nxt  = s1_sample_r;
      len_nxt    = s1_len_r;
      loaded_nxt = 1'b1;
      mode_nxt   = pcmrs_pkg::MODE_STARTING;
      tick_nxt   = 1'b1;
    end else if (s1_req_r == pcmrs_pkg::REQ_STOP) begin
      mode_nxt = pcmrs_pkg::MODE_STOPPING;
    end else if (s1_req_r == pcmrs_pkg::REQ_TICK && tick_r) begin
      if (mode_nxt == pcmrs_pkg::MODE_STARTING) begin
        level_nxt = pcmrs_pkg::step_toward(level_nxt, first_r);
        if (level_nxt == first_r) begin
          mode_nxt = pcmrs_pkg::MODE_PLAYING;
        end
      end
      if (mode_nxt == pcmrs_pkg::MODE_PLAYING) begin
        level_nxt = s1_sample_r;
        idx_nxt   = idx_r + 1'b1;
        if (CMP_W'(idx_nxt) >= CMP_W'(len_r)) begin
          mode_nxt   = pcmrs_pkg::MODE_FINISHING;
          loaded_nxt = 1'b0;
          done_nxt   = 1'b1;
        end
      end
      if (mode_nxt == pcmrs_pkg::MODE_FINISHING) begin
        level_nxt = pcmrs_pkg::step_toward(level_nxt, rest_r);
        if (level_nxt == rest_r) begin
          mode_nxt = pcmrs_pkg::MODE_FINISHED;
        end
      end
      if (mode_nxt == pcmrs_pkg::MODE_STOPPING) begin
        level_nxt = pcmrs_pkg::step_toward(level_nxt, pcmrs_pkg::STOP_LEVEL);
        if (level_nxt == pcmrs_pkg::STOP_LEVEL) begin
          mode_nxt = pcmrs_pkg::MODE_STOPPED;
        end
      end
      if (mode_nxt == pcmrs_pkg::MODE_STOPPED) begin
        tick_nxt = 1'b0;
      end
    end
  end

  assign idx_ext = CMP_W'(idx_nxt);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_req_r    <= pcmrs_pkg::req_t'(in_tuser);
      s1_sample_r <= in_tdata[7:0];
      s1_len_r    <= in_tdata[23:8];
    end
  end

  // sequencer state and rest level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pcmrs_pkg::MODE_STOPPED;
      level_r  <= '0;
      idx_r    <= '0;
      first_r  <= '0;
      len_r    <= '0;
      loaded_r <= 1'b0;
      tick_r   <= 1'b0;
      rest_r   <= pcmrs_pkg::REST_DEFAULT;
    end else begin
      if (s1_adv) begin
        mode_r   <= mode_nxt;
        level_r  <= level_nxt;
        idx_r    <= idx_nxt;
        first_r  <= first_nxt;
        len_r    <= len_nxt;
        loaded_r <= loaded_nxt;
        tick_r   <= tick_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        rest_r <= cfg_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_data_r <= {2'b00, mode_nxt, tick_nxt, done_nxt, loaded_nxt,
                     idx_ext[15:0], level_nxt};
    end
  end

endmodule

FILE: rtl/core/pcmrs_checker.sv
// pcmrs_checker: port-level checks of the pcm playback ramp sequencer
// depends on pcmrs_pkg; bound to the top level below
module pcmrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [2:0] mode_f;
  assign mode_f = out_tdata[pcmrs_pkg::OUT_MODE_MSB:pcmrs_pkg::OUT_MODE_LSB];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // nothing shows right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // done only ends a clip
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[pcmrs_pkg::OUT_DONE_BIT] |->
      !out_tdata[pcmrs_pkg::OUT_BUSY_BIT] &&
      (mode_f == pcmrs_pkg::MODE_FINISHING || mode_f == pcmrs_pkg::MODE_FINISHED))
    else $error("done outside clip end");

  // tick source off only when stopped or stopping
  a_tick_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[pcmrs_pkg::OUT_TICK_BIT] |->
      (mode_f == pcmrs_pkg::MODE_STOPPED || mode_f == pcmrs_pkg::MODE_STOPPING))
    else $error("tick source off while active");

  // stopped mode means level zero
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_f == pcmrs_pkg::MODE_STOPPED |->
      out_tdata[7:0] == pcmrs_pkg::STOP_LEVEL)
    else $error("stopped with nonzero level");

endmodule

bind pcm_playback_ramp_sequencer pcmrs_checker u_pcmrs_checker (.*);

FILE: tb/pcm_playback_ramp_sequencer_tb.sv
// self-checking testbench for pcm_playback_ramp_sequencer: directed and random playback
// requests, a local predictor of the sequencer state, random stalls on both streams
// depends on pcmrs_pkg and the pcm_playback_ramp_sequencer top level
`timescale 1ns / 1ps

module pcm_playback_ramp_sequencer_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    pcmrs_pkg::req_t kind;
    logic [7:0]      sample;
    logic [15:0]     length;
  } play_req_t;

  typedef struct {
    logic [7:0]       level;
    logic [15:0]      index;
    logic             busy;
    logic             done;
    logic             tick;
    pcmrs_pkg::mode_t mode;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // sample_value[7:0], clip_length[23:8]
  logic [1:0]  in_tuser = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // pwm_level[7:0], read_index[23:8], busy_res[24],
                                // done_res[25], tick_enable[26], mode[29:27]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  pcm_playback_ramp_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // predicted sequencer state
  pcmrs_pkg::mode_t mode_q   = pcmrs_pkg::MODE_STOPPED;
  logic [7:0]       level_q  = '0;
  logic [15:0]      index_q  = '0;
  logic [7:0]       first_q  = '0;
  logic [15:0]      length_q = '0;
  logic             loaded_q = 1'b0;
  logic             tick_q   = 1'b0;
  logic [7:0]       rest_q   = pcmrs_pkg::REST_DEFAULT;

  play_req_t pending_reqs[$];
  frame_t    expected_frames[$];
  play_req_t on_bus;
  int        send_idle = 23;
  int        recv_idle = 60;
  int        gen_count = 0;
  int        mismatches = 0;
  bit        pressure_arm = 1'b0;
  bit        hold_used = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  bit        in_busy;
  frame_t    want;

  function automatic logic [7:0] approach(input logic [7:0] lvl, input logic [7:0] goal);
    if (lvl > goal) return lvl - 8'd1;
    if (lvl < goal) return lvl + 8'd1;
    return lvl;
  endfunction

  function automatic frame_t advance_sequencer(input play_req_t r);
    frame_t f;
    logic   finished_clip;
    finished_clip = 1'b0;
    case (r.kind)
      pcmrs_pkg::REQ_START: begin
        index_q  = '0;
        first_q  = r.sample;
        length_q = r.length;
        loaded_q = 1'b1;
        mode_q   = pcmrs_pkg::MODE_STARTING;
        tick_q   = 1'b1;
      end
      pcmrs_pkg::REQ_STOP: mode_q = pcmrs_pkg::MODE_STOPPING;
      pcmrs_pkg::REQ_TICK: begin
        if (tick_q) begin
          if (mode_q == pcmrs_pkg::MODE_STARTING) begin
            level_q = approach(level_q, first_q);
            if (level_q == first_q) mode_q = pcmrs_pkg::MODE_PLAYING;
          end
          if (mode_q == pcmrs_pkg::MODE_PLAYING) begin
            level_q = r.sample;
            index_q = index_q + 16'd1;
            if (index_q >= length_q) begin
              mode_q        = pcmrs_pkg::MODE_FINISHING;
              loaded_q      = 1'b0;
              finished_clip = 1'b1;
            end
          end
          if (mode_q == pcmrs_pkg::MODE_FINISHING) begin
            level_q = approach(level_q, rest_q);
            if (level_q == rest_q) mode_q = pcmrs_pkg::MODE_FINISHED;
          end
          if (mode_q == pcmrs_pkg::MODE_STOPPING) begin
            level_q = approach(level_q, pcmrs_pkg::STOP_LEVEL);
            if (level_q == pcmrs_pkg::STOP_LEVEL) mode_q = pcmrs_pkg::MODE_STOPPED;
          end
          if (mode_q == pcmrs_pkg::MODE_STOPPED) tick_q = 1'b0;
        end
      end
      default: ;
    endcase
    f.level = level_q;
    f.index = index_q;
    f.busy  = loaded_q;
    f.done  = finished_clip;
    f.tick  = tick_q;
    f.mode  = mode_q;
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_frames.push_back(advance_sequencer(on_bus));
        in_busy = 1'b0;
      end else begin
        in_busy = in_tvalid;
      end
      if (!in_busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.kind;
          in_tdata  <= {on_bus.length, on_bus.sample};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          flag_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_tdata[7:0] != want.level)
            flag_mismatch("pwm_level", out_tdata[7:0], want.level);
          if (out_tdata[23:8] != want.index)
            flag_mismatch("read_index", out_tdata[23:8], want.index);
          if (out_tdata[pcmrs_pkg::OUT_BUSY_BIT] != want.busy)
            flag_mismatch("busy_res", out_tdata[pcmrs_pkg::OUT_BUSY_BIT], want.busy);
          if (out_tdata[pcmrs_pkg::OUT_DONE_BIT] != want.done)
            flag_mismatch("done_res", out_tdata[pcmrs_pkg::OUT_DONE_BIT], want.done);
          if (out_tdata[pcmrs_pkg::OUT_TICK_BIT] != want.tick)
            flag_mismatch("tick_enable", out_tdata[pcmrs_pkg::OUT_TICK_BIT], want.tick);
          if (out_tdata[pcmrs_pkg::OUT_MODE_MSB:pcmrs_pkg::OUT_MODE_LSB] != want.mode)
            flag_mismatch("mode", out_tdata[pcmrs_pkg::OUT_MODE_MSB:pcmrs_pkg::OUT_MODE_LSB],
                          want.mode);
          if (out_tdata[31:30] != 2'b00) flag_mismatch("pad bits", out_tdata[31:30], 0);
        end
      end
      if (pressure_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pcm_playback_ramp_sequencer regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(input pcmrs_pkg::req_t kind, input int sample, input int length);
    play_req_t r;
    r.kind   = kind;
    r.sample = sample[7:0];
    r.length = length[15:0];
    pending_reqs.push_back(r);
    gen_count++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_frames.size() != 0);
  endtask

  task automatic write_rest(input logic [7:0] value);
    wait_quiet();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rest_q = value;
    @(negedge clk);
  endtask

  function automatic int clamp_level(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // start mostly near the current level, play a mostly short clip, land the last sample near rest
  task automatic play_clip();
    int lvl, first, gap, len, last_play, n, s;
    wait_quiet();
    lvl = level_q;
    if ($urandom_range(0, 4) == 0) first = $urandom_range(0, 255);
    else first = clamp_level(lvl + $urandom_range(0, 8) - 4);
    if ($urandom_range(0, 19) == 0)
      len = $urandom_range(0, 1) ? 65535 : $urandom_range(7, 65535);
    else
      len = $urandom_range(0, 6);
    gap = (first > lvl) ? first - lvl : lvl - first;
    last_play = ((gap > 0) ? gap : 1) + ((len > 0) ? len : 1) - 1;
    if (len > 6) n = ((gap > 0) ? gap : 1) + $urandom_range(0, 30);
    else n = last_play + $urandom_range(0, 6);
    push_req(pcmrs_pkg::REQ_START, first, len);
    for (int k = 1; k <= n; k++) begin
      if (k == last_play) s = clamp_level(rest_q + $urandom_range(0, 6) - 3);
      else s = $urandom_range(0, 255);
      push_req(pcmrs_pkg::REQ_TICK, s, $urandom_range(0, 65535));
    end
  endtask

  task automatic stop_run();
    int n;
    wait_quiet();
    if (level_q <= 48) n = level_q + $urandom_range(0, 4);
    else n = $urandom_range(0, 8);
    push_req(pcmrs_pkg::REQ_STOP, $urandom_range(0, 255), $urandom_range(0, 65535));
    for (int k = 0; k < n; k++)
      push_req(pcmrs_pkg::REQ_TICK, $urandom_range(0, 255), $urandom_range(0, 65535));
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(4, 12);
    for (int k = 0; k < n; k++)
      push_req(pcmrs_pkg::req_t'($urandom_range(0, 3)), $urandom_range(0, 255),
               $urandom_range(0, 65535));
  endtask

  task automatic run_random(input int target);
    int pick;
    while (gen_count < target) begin
      wait_quiet();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        play_clip();
        if ($urandom_range(0, 2) == 0) stop_run();
      end else if (pick < 80) begin
        stop_run();
      end else begin
        noise_burst();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ignored ticks, restarts, zero length, stop to zero
    push_req(pcmrs_pkg::REQ_TICK, 8'hAA, 0);
    push_req(pcmrs_pkg::REQ_STOP, 0, 0);
    push_req(pcmrs_pkg::REQ_NONE, 8'hFF, 16'hFFFF);
    push_req(pcmrs_pkg::REQ_START, 2, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h55, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'hFF, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h00, 16'hFFFF);
    push_req(pcmrs_pkg::REQ_NONE, 0, 0);
    push_req(pcmrs_pkg::REQ_START, 8'hFF, 16'hFFFF);
    push_req(pcmrs_pkg::REQ_TICK, 8'h0F, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'hF0, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h00, 0);
    push_req(pcmrs_pkg::REQ_START, 1, 2);
    push_req(pcmrs_pkg::REQ_TICK, 8'h03, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h00, 0);
    push_req(pcmrs_pkg::REQ_STOP, 8'hFF, 16'hFFFF);
    push_req(pcmrs_pkg::REQ_TICK, 8'h00, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h77, 0);
    push_req(pcmrs_pkg::REQ_START, 0, 1);
    push_req(pcmrs_pkg::REQ_TICK, 8'h80, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h12, 0);
    push_req(pcmrs_pkg::REQ_STOP, 0, 0);
    push_req(pcmrs_pkg::REQ_TICK, 8'h34, 0);

    write_rest(8'd0);
    run_random(220);

    send_idle = 60;
    recv_idle = 23;
    write_rest(8'd255);
    run_random(420);

    send_idle = 0;
    recv_idle = 0;
    write_rest(8'($urandom_range(1, 254)));
    // receiver stalls long while requests keep coming
    pressure_arm = 1'b1;
    noise_burst();
    run_random(620);

    wait_quiet();
    repeat (5) @(posedge clk);
    if (expected_frames.size() != 0) flag_mismatch("results left over", expected_frames.size(), 0);
    if (mismatches == 0) begin
      $display("pcm_playback_ramp_sequencer regression: pass");
    end else begin
      $display("pcm_playback_ramp_sequencer regression: fail");
    end
    $finish;
  end

endmodule
